@@ design/fci_pkg.sv @@
// fci_pkg: shared constants, types and helpers of the flash command interface
// no dependencies; compiled first

package fci_pkg;

  // geometry, sizes kept as powers of two
  localparam int BANK_LOG2    = 16;
  localparam int BANK_BYTES   = 1 << BANK_LOG2;
  localparam int BANK_COUNT   = 2;
  localparam int SECTOR_LOG2  = 12;
  localparam int SECTOR_BYTES = 1 << SECTOR_LOG2;

  // erase span is clipped to the bank
  localparam int ERASE_LOG2   = (SECTOR_LOG2 < BANK_LOG2) ? SECTOR_LOG2 : BANK_LOG2;
  localparam int ERASE_BYTES  = 1 << ERASE_LOG2;

  localparam int STORE_DEPTH  = BANK_BYTES * BANK_COUNT;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);

  // bus field widths
  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int CFG_IDX_W    = 2;

  // command protocol codes
  localparam logic [ADDR_W-1:0] CMD_ADDR1 = 16'h5555;
  localparam logic [ADDR_W-1:0] CMD_ADDR2 = 16'h2AAA;
  localparam logic [ADDR_W-1:0] BANK_SEL_ADDR = 16'h0000;
  localparam logic [ADDR_W-1:0] ID_MAKER_ADDR = 16'h0000;
  localparam logic [ADDR_W-1:0] ID_DEVICE_ADDR = 16'h0001;
  localparam logic [DATA_W-1:0] BYTE_UNLOCK1 = 8'hAA;
  localparam logic [DATA_W-1:0] BYTE_UNLOCK2 = 8'h55;
  localparam logic [DATA_W-1:0] CMD_PROGRAM  = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_BANK_SEL = 8'hB0;
  localparam logic [DATA_W-1:0] CMD_ID_ENTER = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT  = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ARM      = 8'h80;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] ERASED_BYTE  = 8'hFF;

  localparam logic [STORE_AW-1:0] ERASE_MASK = STORE_AW'(ERASE_BYTES - 1);

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAKER_ID  = 2'd0,
    CFG_DEVICE_ID = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_UNLOCK1,
    SEQ_UNLOCK2,
    SEQ_PROGRAM,
    SEQ_BANKSEL,
    SEQ_ARMED,
    SEQ_ERASE1,
    SEQ_ERASE2
  } seq_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } ctl_state_t;

  // mode flags seen on every result word
  typedef struct packed {
    logic id_mode;
    logic bank;
  } fci_flags_t;

  // store actions decoded from a write word
  typedef struct packed {
    logic prog;
    logic erase;
  } fci_act_t;

  // sweep engine status toward the store port
  typedef struct packed {
    logic                busy;
    logic [STORE_AW-1:0] addr;
  } fci_sweep_t;

  // bank plus wrapped offset into the flat store
  function automatic logic [STORE_AW-1:0] store_index(logic bank, logic [ADDR_W-1:0] addr);
    logic [STORE_AW-1:0] off;
    logic [STORE_AW-1:0] bank_base;
    off       = STORE_AW'(addr[BANK_LOG2-1:0]);
    bank_base = (bank && (BANK_COUNT > 1)) ? STORE_AW'(BANK_BYTES) : '0;
    return off | bank_base;
  endfunction

endpackage

@@ design/fci_if.sv @@
// fci_if: valid/ready channel interfaces of the flash command interface
// depends on fci_pkg

interface fci_in_if;
  import fci_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input address, input write_data,
                output ready);
endinterface

interface fci_out_if;
  import fci_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              id_mode_active;
  logic              bank_selected;
  modport source (output valid, output read_data, output id_mode_active,
                  output bank_selected, input ready);
  modport sink (input valid, input read_data, input id_mode_active,
                input bank_selected, output ready);
endinterface

interface fci_cfg_if;
  import fci_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/fci_ram.sv @@
// fci_ram: single-port byte store of the flash array with a registered read
// depends on fci_pkg

module fci_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [fci_pkg::STORE_AW-1:0] addr,
  input  logic [fci_pkg::DATA_W-1:0]   wr_data,
  output logic [fci_pkg::DATA_W-1:0]   rd_data
);
  import fci_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/fci_sweep.sv @@
// fci_sweep: fill engine writing erased bytes, whole store after reset, one sector on erase
// depends on fci_pkg

module fci_sweep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fci_pkg::STORE_AW-1:0] start_base,
  output fci_pkg::fci_sweep_t          status
);
  import fci_pkg::*;

  logic                busy_r, busy_nxt;
  logic [STORE_AW-1:0] base_r, base_nxt;
  logic [STORE_AW-1:0] cnt_r, cnt_nxt;
  logic [STORE_AW-1:0] last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      base_r <= '0;
      cnt_r  <= '0;
      last_r <= '1;
    end else begin
      busy_r <= busy_nxt;
      base_r <= base_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    base_nxt = base_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (busy_r) begin
      if (cnt_r == last_r) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      base_nxt = start_base & ~ERASE_MASK;
      cnt_nxt  = '0;
      last_nxt = ERASE_MASK;
    end
  end

  assign status.busy = busy_r;
  assign status.addr = base_r | cnt_r;

endmodule

@@ design/fci_cmd.sv @@
// fci_cmd: command sequence decoder holding sequence step, id mode and bank
// depends on fci_pkg

module fci_cmd (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_fire,
  input  logic [fci_pkg::ADDR_W-1:0] address,
  input  logic [fci_pkg::DATA_W-1:0] write_data,
  output fci_pkg::fci_act_t          act,
  output fci_pkg::fci_flags_t        flags,
  output fci_pkg::fci_flags_t        flags_nxt
);
  import fci_pkg::*;

  seq_t       seq_r, seq_nxt;
  fci_flags_t flags_r, flags_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= SEQ_IDLE;
      flags_r <= '0;
    end else begin
      seq_r   <= seq_nxt;
      flags_r <= flags_upd;
    end
  end

  always_comb begin
    seq_nxt     = seq_r;
    flags_upd   = flags_r;
    act         = '0;
    if (wr_fire) begin
      seq_nxt = SEQ_IDLE;
      case (seq_r)
        SEQ_IDLE: begin
          if (address == CMD_ADDR1 && write_data == BYTE_UNLOCK1) begin
            seq_nxt = SEQ_UNLOCK1;
          end
        end
        SEQ_UNLOCK1: begin
          if (address == CMD_ADDR2 && write_data == BYTE_UNLOCK2) begin
            seq_nxt = SEQ_UNLOCK2;
          end
        end
        SEQ_UNLOCK2: begin
          if (address == CMD_ADDR1) begin
            case (write_data)
              CMD_PROGRAM:  seq_nxt = SEQ_PROGRAM;
              CMD_BANK_SEL: seq_nxt = SEQ_BANKSEL;
              CMD_ID_ENTER: flags_upd.id_mode = 1'b1;
              CMD_ID_EXIT:  flags_upd.id_mode = 1'b0;
              CMD_ARM:      seq_nxt = SEQ_ARMED;
              default:      seq_nxt = SEQ_IDLE;
            endcase
          end
        end
        SEQ_PROGRAM: begin
          act.prog = 1'b1;
        end
        SEQ_BANKSEL: begin
          // a missing bank falls back to bank 0
          if (address == BANK_SEL_ADDR) begin
            flags_upd.bank = (BANK_COUNT > 1) ? write_data[0] : 1'b0;
          end
        end
        SEQ_ARMED: begin
          if (address == CMD_ADDR1 && write_data == BYTE_UNLOCK1) begin
            seq_nxt = SEQ_ERASE1;
          end
        end
        SEQ_ERASE1: begin
          if (address == CMD_ADDR2 && write_data == BYTE_UNLOCK2) begin
            seq_nxt = SEQ_ERASE2;
          end
        end
        SEQ_ERASE2: begin
          act.erase = (write_data == CMD_SECTOR_ERASE);
        end
        default: begin
          seq_nxt = SEQ_IDLE;
        end
      endcase
    end
  end

  assign flags     = flags_r;
  assign flags_nxt = flags_upd;

endmodule

@@ design/flash_command_interface_unit.sv @@
// flash_command_interface_unit: top level of the banked parallel flash model
// depends on fci_pkg, fci_if, fci_ram, fci_sweep and fci_cmd

// Bus-side model of a banked parallel flash with the usual unlock/command protocol.
// Each input word is one read or write access; each produces exactly one result word
// showing the read byte (zero for writes), id mode and the selected bank after the access.
// A write or an id-mode read of offset 0 or 1 goes straight into the result register; an
// array read first waits in the read state for the registered byte of the single-port store.
// A sector erase keeps the input closed while the sweep engine writes 0xFF one byte per
// cycle through the same store port. After reset the same engine clears the whole store,
// during which no input word is accepted; config writes are taken at any time.
// The result sits in an output register; a new input word is taken once that register is
// empty or being emptied in the same cycle.

module flash_command_interface_unit (
  input  logic         clk,
  input  logic         rst_n,
  fci_in_if.sink       in_ch,
  fci_out_if.source    out_ch,
  fci_cfg_if.sink      cfg_ch
);
  import fci_pkg::*;

  // id registers, written from the config port
  logic [DATA_W-1:0] maker_id_r, device_id_r;

  // control
  ctl_state_t state_r, state_nxt;
  logic       in_fire, wr_fire, id_read;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  fci_flags_t        out_flags_r, out_flags_nxt;

  // submodule links
  fci_act_t            act;
  fci_flags_t          flags, flags_nxt;
  fci_sweep_t          sweep;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;

  // config port never stalls
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maker_id_r  <= 8'd194;
      device_id_r <= 8'd9;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAKER_ID:  maker_id_r  <= cfg_ch.data;
        CFG_DEVICE_ID: device_id_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // input side: closed while a read waits, while sweeping, or while the result is stuck
  assign in_ch.ready = (state_r == ST_IDLE) && !sweep.busy
                       && (!out_valid_r || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign wr_fire = in_fire && (in_ch.opcode == OP_WRITE);
  assign id_read = flags.id_mode && ((in_ch.address == ID_MAKER_ADDR)
                                     || (in_ch.address == ID_DEVICE_ADDR));

  fci_cmd u_cmd (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_fire    (wr_fire),
    .address    (in_ch.address),
    .write_data (in_ch.write_data),
    .act        (act),
    .flags      (flags),
    .flags_nxt  (flags_nxt)
  );

  // sector base taken in the bank that is current at the erase command
  fci_sweep u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (wr_fire && act.erase),
    .start_base (store_index(flags.bank, in_ch.address)),
    .status     (sweep)
  );

  // single store port: sweep fill, else program write or array read of the accepted word
  always_comb begin
    if (sweep.busy) begin
      ram_we      = 1'b1;
      ram_addr    = sweep.addr;
      ram_wr_data = ERASED_BYTE;
    end else begin
      ram_we      = wr_fire && act.prog;
      ram_addr    = store_index(flags.bank, in_ch.address);
      ram_wr_data = in_ch.write_data;
    end
  end

  fci_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wr_data (ram_wr_data),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_flags_r <= out_flags_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_flags_nxt = out_flags_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == OP_WRITE) begin
            // writes report the flags after the access
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_flags_nxt = flags_nxt;
          end else if (id_read) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = (in_ch.address == ID_MAKER_ADDR) ? maker_id_r : device_id_r;
            out_flags_nxt = flags;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        // store data arrives in the cycle after the address
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rd_data;
        out_flags_nxt = flags;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = out_data_r;
  assign out_ch.id_mode_active = out_flags_r.id_mode;
  assign out_ch.bank_selected  = out_flags_r.bank;

`ifndef SYNTH
  // an array read always lands in the result register on the next edge
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid_r)
    else $error("array read lost its result");

  // an erase command closes the input for the sweep
  a_erase_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_fire && act.erase) |=> (sweep.busy && !in_ch.ready))
    else $error("erase did not start the sweep");

  // a pending read must not see its result slot occupied
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("read result would overwrite a waiting word");

  // program writes never collide with the sweep on the store port
  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    sweep.busy |-> !in_fire)
    else $error("input accepted during sweep");
`endif

endmodule

@@ test/tb_flash_command_interface_unit.sv @@
`timescale 1ns / 100ps
// tb_flash_command_interface_unit: self-checking bench for the banked flash command interface
// depends on fci_pkg, fci_if and the flash_command_interface_unit design files

module tb_flash_command_interface_unit;
  import fci_pkg::*;

  // id register values after reset
  localparam logic [DATA_W-1:0] MAKER_ID_RESET  = 8'd194;
  localparam logic [DATA_W-1:0] DEVICE_ID_RESET = 8'd9;

  // receiver hold-off used to back the block up into its input
  localparam int LONG_HOLD     = 300;
  // quiet cycles after the last result of a phase
  localparam int SETTLE_CYCLES = 16;

  // one bus access as offered on the input channel
  typedef struct {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } flash_access_t;

  // one result word as seen on the output channel
  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              id_mode;
    logic              bank;
  } flash_result_t;

  logic clk;
  logic rst_n;

  fci_in_if  in_ch();
  fci_out_if out_ch();
  fci_cfg_if cfg_ch();

  flash_command_interface_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow of the chip: byte array, command sequencer, mode and bank, id registers
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] flash_image [STORE_DEPTH];
  seq_t              cmd_step;
  logic              id_mode_q;
  logic              bank_q;
  logic [DATA_W-1:0] maker_id_q;
  logic [DATA_W-1:0] device_id_q;

  // words waiting to be offered, and results owed by the block in order
  flash_access_t pending_accesses[$];
  flash_result_t results_due[$];

  int  words_queued;
  int  mismatch_count;
  int  stray_count;
  bit  idling_on;
  bit  hold_arm;
  int  hold_left;
  int  src_gap;
  int  sink_gap;

  flash_result_t seen_result;
  flash_result_t want_result;

  // apply one access to the shadow chip and return the result word it owes
  function automatic flash_result_t apply_access(flash_access_t acc);
    flash_result_t       r;
    seq_t                nxt;
    logic [STORE_AW-1:0] idx;
    int                  base;
    int                  stop;
    int                  j;
    r.read_data = '0;
    // data offsets wrap inside the bank, command offsets compare at full width
    idx = (STORE_AW'(bank_q) << BANK_LOG2) | STORE_AW'(acc.address[BANK_LOG2-1:0]);
    if (acc.op == OP_WRITE) begin
      // anything not matching the expected next step falls back to idle
      nxt = SEQ_IDLE;
      case (cmd_step)
        SEQ_IDLE: begin
          if (acc.address == CMD_ADDR1 && acc.write_data == BYTE_UNLOCK1) nxt = SEQ_UNLOCK1;
        end
        SEQ_UNLOCK1: begin
          if (acc.address == CMD_ADDR2 && acc.write_data == BYTE_UNLOCK2) nxt = SEQ_UNLOCK2;
        end
        SEQ_UNLOCK2: begin
          if (acc.address == CMD_ADDR1) begin
            case (acc.write_data)
              CMD_PROGRAM:  nxt = SEQ_PROGRAM;
              CMD_BANK_SEL: nxt = SEQ_BANKSEL;
              CMD_ID_ENTER: id_mode_q = 1'b1;
              CMD_ID_EXIT:  id_mode_q = 1'b0;
              CMD_ARM:      nxt = SEQ_ARMED;
              default: ;
            endcase
          end
        end
        SEQ_PROGRAM: begin
          // plain store, no and with the old byte
          flash_image[idx] = acc.write_data;
        end
        SEQ_BANKSEL: begin
          // only bit 0 counts; a bank that does not exist maps to bank 0
          if (acc.address == BANK_SEL_ADDR)
            bank_q = (int'(acc.write_data[0]) < BANK_COUNT) ? acc.write_data[0] : 1'b0;
        end
        SEQ_ARMED: begin
          if (acc.address == CMD_ADDR1 && acc.write_data == BYTE_UNLOCK1) nxt = SEQ_ERASE1;
        end
        SEQ_ERASE1: begin
          if (acc.address == CMD_ADDR2 && acc.write_data == BYTE_UNLOCK2) nxt = SEQ_ERASE2;
        end
        SEQ_ERASE2: begin
          // erase the sector holding the offset, clipped at the end of the bank
          if (acc.write_data == CMD_SECTOR_ERASE) begin
            base = (int'(acc.address[BANK_LOG2-1:0]) / SECTOR_BYTES) * SECTOR_BYTES;
            stop = base + SECTOR_BYTES;
            if (stop > BANK_BYTES) stop = BANK_BYTES;
            for (j = base; j < stop; j++)
              flash_image[(STORE_AW'(bank_q) << BANK_LOG2) | STORE_AW'(j)] = ERASED_BYTE;
          end
        end
        default: ;
      endcase
      cmd_step = nxt;
    end else if (id_mode_q && acc.address == ID_MAKER_ADDR) begin
      r.read_data = maker_id_q;
    end else if (id_mode_q && acc.address == ID_DEVICE_ADDR) begin
      r.read_data = device_id_q;
    end else begin
      r.read_data = flash_image[idx];
    end
    r.id_mode = id_mode_q;
    r.bank    = bank_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers queued words, holds each until taken, idles in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      // word taken at this edge: it is the head of the queue
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(apply_access(pending_accesses.pop_front()));
      if (in_ch.valid && !in_ch.ready) begin
        // stalled, keep the word on the bus
      end else if (src_gap != 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        // start an idle burst that includes this cycle
        src_gap = $urandom_range(0, 13);
        in_ch.valid <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= pending_accesses[0].op;
        in_ch.address    <= pending_accesses[0].address;
        in_ch.write_data <= pending_accesses[0].write_data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps running meanwhile
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (hold_arm)
      hold_left <= LONG_HOLD;
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each taken word against the oldest result owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_result.read_data = out_ch.read_data;
        seen_result.id_mode   = out_ch.id_mode_active;
        seen_result.bank      = out_ch.bank_selected;
        if (results_due.size() == 0) begin
          // a result word that no access asked for
          stray_count++;
          if (stray_count + mismatch_count <= 10)
            $display("%0t: unexpected result word data=%h id=%b bank=%b", $realtime,
                     seen_result.read_data, seen_result.id_mode, seen_result.bank);
        end else begin
          want_result = results_due.pop_front();
          if (seen_result.read_data !== want_result.read_data ||
              seen_result.id_mode !== want_result.id_mode ||
              seen_result.bank !== want_result.bank) begin
            mismatch_count++;
            if (stray_count + mismatch_count <= 10)
              $display("%0t: mismatch data exp %h got %h, id exp %b got %b, bank exp %b got %b",
                       $realtime, want_result.read_data, seen_result.read_data,
                       want_result.id_mode, seen_result.id_mode,
                       want_result.bank, seen_result.bank);
          end
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building blocks
  // ---------------------------------------------------------------------------
  task automatic push_access(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    flash_access_t acc;
    acc.op         = op;
    acc.address    = addr;
    acc.write_data = data;
    pending_accesses.push_back(acc);
    words_queued++;
  endtask

  // reads carry random write data, the block must ignore it
  task automatic push_read(logic [ADDR_W-1:0] addr);
    push_access(OP_READ, addr, 8'($urandom));
  endtask

  task automatic push_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    push_access(OP_WRITE, addr, data);
  endtask

  task automatic push_unlock();
    push_write(CMD_ADDR1, BYTE_UNLOCK1);
    push_write(CMD_ADDR2, BYTE_UNLOCK2);
  endtask

  task automatic push_command(logic [DATA_W-1:0] cmd);
    push_unlock();
    push_write(CMD_ADDR1, cmd);
  endtask

  task automatic push_erase(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] last_byte);
    push_command(CMD_ARM);
    push_unlock();
    push_write(addr, last_byte);
  endtask

  // offsets cluster at both ends of the bank so reads find programmed bytes
  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 3))
      0: return ADDR_W'($urandom);
      1: return ADDR_W'($urandom_range(0, 31));
      2: return ADDR_W'(BANK_BYTES - 1 - $urandom_range(0, 31));
      default: begin
        case ($urandom_range(0, 3))
          0: return CMD_ADDR1;
          1: return CMD_ADDR2;
          2: return ID_MAKER_ADDR;
          default: return ID_DEVICE_ADDR;
        endcase
      end
    endcase
  endfunction

  // mostly well-formed command sequences with random content, plus noise
  task automatic queue_random(int count, int erase_budget);
    int start;
    int pick;
    start = words_queued;
    while (words_queued - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        push_command(CMD_PROGRAM);
        push_write(pick_address(), 8'($urandom));
      end else if (pick < 45) begin
        push_read(pick_address());
      end else if (pick < 52) begin
        // bank select, now and then at a nonzero offset
        push_command(CMD_BANK_SEL);
        push_write(($urandom_range(0, 4) == 0) ? pick_address() : BANK_SEL_ADDR,
                   8'($urandom));
      end else if (pick < 62) begin
        push_command($urandom_range(0, 1) ? CMD_ID_ENTER : CMD_ID_EXIT);
        push_read(ID_MAKER_ADDR);
        push_read(ID_DEVICE_ADDR);
      end else if (pick < 65 && erase_budget > 0) begin
        // sector erase, sometimes with a wrong final byte
        erase_budget--;
        push_erase(pick_address(),
                   ($urandom_range(0, 4) == 0) ? 8'($urandom) : CMD_SECTOR_ERASE);
      end else if (pick < 82) begin
        // broken sequences at various depths
        case ($urandom_range(0, 3))
          0: begin
            push_write(CMD_ADDR1, BYTE_UNLOCK1);
            push_write(pick_address(), 8'($urandom));
          end
          1: begin
            push_unlock();
            push_write(pick_address(), 8'($urandom));
          end
          2: begin
            push_unlock();
            push_write(CMD_ADDR1, 8'($urandom));
          end
          default: begin
            push_command(CMD_ARM);
            if ($urandom_range(0, 1)) push_write(CMD_ADDR1, BYTE_UNLOCK1);
            push_write(pick_address(), 8'($urandom));
          end
        endcase
      end else begin
        // lone noise word
        if ($urandom_range(0, 1))
          push_write(pick_address(), 8'($urandom));
        else
          push_read(ADDR_W'($urandom));
      end
    end
  endtask

  // register write over the config channel, for use only while the block is idle; the task does not enforce it
  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MAKER_ID:  maker_id_q = value;
      CFG_DEVICE_ID: device_id_q = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // every queued word offered and every result word back, then a quiet settle spell
  task automatic wait_drained();
    while (pending_accesses.size() != 0 || results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = 1'b0;
    in_ch.address    = '0;
    in_ch.write_data = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_MAKER_ID;
    cfg_ch.data      = '0;
    hold_arm         = 1'b0;
    idling_on        = 1'b1;
    words_queued     = 0;
    mismatch_count   = 0;
    stray_count      = 0;

    // shadow chip starts erased, idle, bank 0, id registers at reset values
    for (int i = 0; i < STORE_DEPTH; i++) flash_image[i] = ERASED_BYTE;
    cmd_step    = SEQ_IDLE;
    id_mode_q   = 1'b0;
    bank_q      = 1'b0;
    maker_id_q  = MAKER_ID_RESET;
    device_id_q = DEVICE_ID_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words; the block's clearing pass after reset just delays them
    push_read(16'hFFFF);
    push_command(CMD_PROGRAM);
    push_write(16'hFFFF, 8'h00);
    push_read(16'hFFFF);
    // id mode with the reset id values, offset 2 still reads the array
    push_command(CMD_ID_ENTER);
    push_read(ID_MAKER_ADDR);
    push_read(ID_DEVICE_ADDR);
    push_read(16'h0002);
    push_command(CMD_ID_EXIT);
    // bank from bit 0 of an all-ones byte, then a select at a nonzero offset
    push_command(CMD_BANK_SEL);
    push_write(BANK_SEL_ADDR, 8'hFF);
    push_command(CMD_BANK_SEL);
    push_write(ID_DEVICE_ADDR, 8'h00);
    // erase of the last sector in bank 1
    push_erase(16'hF123, CMD_SECTOR_ERASE);
    push_read(16'hFFFF);
    wait_drained();

    // opposite extremes of the id registers
    write_reg(CFG_MAKER_ID, 8'hFF);
    write_reg(CFG_DEVICE_ID, 8'h00);
    queue_random(220, 6);
    wait_drained();

    write_reg(CFG_MAKER_ID, 8'h00);
    write_reg(CFG_DEVICE_ID, 8'hFF);
    queue_random(200, 6);
    // back the block up: receiver holds off while the sender keeps offering
    hold_arm = 1'b1;
    while (hold_left == 0) @(negedge clk);
    hold_arm = 1'b0;
    wait_drained();

    // last stretch with no idling on either side
    idling_on = 1'b0;
    write_reg(CFG_MAKER_ID, 8'($urandom));
    write_reg(CFG_DEVICE_ID, 8'($urandom));
    queue_random(280, 8);
    wait_drained();

    if (mismatch_count == 0 && stray_count == 0 && results_due.size() == 0)
      $display("tb_flash_command_interface_unit OK");
    else
      $display("tb_flash_command_interface_unit NOT OK");
    $finish;
  end

  // watchdog, well beyond the clearing pass plus every erase and stall
  initial begin
    #3_000_000;
    $display("tb_flash_command_interface_unit NOT OK");
    $finish;
  end

endmodule
